// ===== design/pbb_pkg.sv =====
package pbb_pkg;

    localparam int SCREEN_COLUMNS = 128;
    localparam int SCREEN_PAGES   = 8;
    localparam int STORE_DEPTH    = SCREEN_COLUMNS * SCREEN_PAGES;
    localparam int ADDR_W         = $clog2(STORE_DEPTH);

    // Input function codes.
    localparam logic [1:0] FUNC_START = 2'd0;
    localparam logic [1:0] FUNC_BYTE  = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    // Draw modes; the remaining codes invert.
    localparam logic [1:0] MODE_SET   = 2'd0;
    localparam logic [1:0] MODE_CLEAR = 2'd1;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] CFG_ORIGIN_X      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ORIGIN_Y      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BITMAP_WIDTH  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_BITMAP_HEIGHT = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_DRAW_MODE     = 3'd4;

    typedef enum logic [1:0] {
        OP_NOP,
        OP_MERGE,
        OP_READ
    } op_kind_t;

    typedef struct packed {
        op_kind_t          kind;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        mask;
        logic [1:0]        mode;
        logic              last;
        logic              done;
    } mem_op_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] read_data;
        logic       blit_done;
    } result_t;

    typedef struct packed {
        logic [7:0] origin_x;
        logic [7:0] origin_y;
        logic [7:0] bitmap_width;
        logic [7:0] bitmap_height;
        logic [1:0] draw_mode;
    } blit_cfg_t;

endpackage

// ===== design/pbb_front.sv =====
module pbb_front (
    input  logic               clk,
    input  logic               rst_n,
    input  pbb_pkg::blit_cfg_t cfg,
    input  logic               hold,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         func,
    input  logic [7:0]         bitmap_byte,
    input  logic [9:0]         read_address,
    output logic               issue_valid,
    input  logic               issue_ready,
    output pbb_pkg::mem_op_t   issue_op
);

    localparam int AW = pbb_pkg::ADDR_W;

    logic       active_reg, active_next;
    logic [7:0] column_count_reg, column_count_next;
    logic [5:0] page_index_reg, page_index_next;

    logic             slot_valid_reg;
    logic             slot_two_reg;
    logic             slot_phase_reg;
    pbb_pkg::mem_op_t op_a_reg, op_a_next;
    pbb_pkg::mem_op_t op_b_reg, op_b_next;
    logic             two_next;

    logic              accept, fire, leaving;
    logic signed [4:0] top_page;
    logic signed [7:0] tp8;
    logic [2:0]        offset;
    logic signed [9:0] ox_w, oy_w, x_end, y_end;
    logic [5:0]        h_pages;
    logic signed [7:0] last_raw, last_pg, pg_diff;
    logic              empty;
    logic [6:0]        pages;
    logic signed [7:0] page, page1;
    logic signed [9:0] col;
    logic              col_ok, m0_ok, m1_ok;
    logic [7:0]        mask0, mask1;
    logic [2:0]        rshift;
    logic [AW-1:0]     addr0, addr1;
    logic [8:0]        next_col;
    logic [5:0]        pi_inc;
    logic              blit_end;
    pbb_pkg::mem_op_t  merge0, merge1, nop_op;

    // Placement: floor and modulo of origin_y by eight, then the page count.
    assign top_page = cfg.origin_y[7:3];
    assign tp8      = {{3{top_page[4]}}, top_page};
    assign offset   = cfg.origin_y[2:0];
    assign ox_w     = {{2{cfg.origin_x[7]}}, cfg.origin_x};
    assign oy_w     = {{2{cfg.origin_y[7]}}, cfg.origin_y};
    assign x_end    = ox_w + {2'b00, cfg.bitmap_width};
    assign y_end    = oy_w + {2'b00, cfg.bitmap_height};
    assign h_pages  = 6'(({1'b0, cfg.bitmap_height} + 9'd7) >> 3);
    assign last_raw = tp8 + {2'b00, h_pages};
    assign last_pg  = (last_raw > $signed(8'(pbb_pkg::SCREEN_PAGES)))
                      ? $signed(8'(pbb_pkg::SCREEN_PAGES)) : last_raw;
    assign pg_diff  = last_pg - tp8;
    assign empty    = (cfg.bitmap_width == 8'd0) || (cfg.bitmap_height == 8'd0)
                      || x_end[9] || y_end[9]
                      || (oy_w > $signed(10'(pbb_pkg::SCREEN_PAGES * 8 - 1)));
    assign pages    = (empty || pg_diff[7] || pg_diff == 8'sd0) ? 7'd0 : pg_diff[6:0];

    // Where the current bitmap byte lands.
    assign page   = tp8 + {2'b00, page_index_reg};
    assign page1  = page + 8'sd1;
    assign col    = ox_w + {2'b00, column_count_reg};
    assign col_ok = !col[9] && (col <= $signed(10'(pbb_pkg::SCREEN_COLUMNS - 1)));
    assign m0_ok  = col_ok && !page[7] && (page < $signed(8'(pbb_pkg::SCREEN_PAGES)));
    assign m1_ok  = col_ok && (offset != 3'd0) && (page >= -8'sd1)
                    && (page < $signed(8'(pbb_pkg::SCREEN_PAGES - 1)));
    assign rshift = 3'(4'd8 - {1'b0, offset});
    assign mask0  = bitmap_byte << offset;
    assign mask1  = bitmap_byte >> rshift;
    assign addr0  = AW'(page) * AW'(pbb_pkg::SCREEN_COLUMNS) + AW'(col);
    assign addr1  = AW'(page1) * AW'(pbb_pkg::SCREEN_COLUMNS) + AW'(col);

    assign next_col = {1'b0, column_count_reg} + 9'd1;
    assign pi_inc   = page_index_reg + 6'd1;
    assign blit_end = next_col >= {1'b0, cfg.bitmap_width} && {1'b0, pi_inc} >= pages;

    always_comb
    begin
        nop_op      = '0;
        nop_op.kind = pbb_pkg::OP_NOP;
        nop_op.mode = cfg.draw_mode;
        nop_op.last = 1'b1;

        merge0      = nop_op;
        merge0.kind = pbb_pkg::OP_MERGE;
        merge0.addr = addr0;
        merge0.mask = mask0;

        merge1      = nop_op;
        merge1.kind = pbb_pkg::OP_MERGE;
        merge1.addr = addr1;
        merge1.mask = mask1;

        op_a_next         = nop_op;
        op_b_next         = nop_op;
        two_next          = 1'b0;
        active_next       = active_reg;
        column_count_next = column_count_reg;
        page_index_next   = page_index_reg;

        unique case (func)
            pbb_pkg::FUNC_START:
            begin
                column_count_next = 8'd0;
                page_index_next   = 6'd0;
                active_next       = (pages != 7'd0);
                op_a_next.done    = (pages == 7'd0);
            end
            pbb_pkg::FUNC_BYTE:
            begin
                if (active_reg)
                begin
                    if (m0_ok && m1_ok)
                    begin
                        two_next       = 1'b1;
                        op_a_next      = merge0;
                        op_a_next.last = 1'b0;
                        op_b_next      = merge1;
                        op_b_next.done = blit_end;
                    end
                    else if (m0_ok)
                    begin
                        op_a_next      = merge0;
                        op_a_next.done = blit_end;
                    end
                    else if (m1_ok)
                    begin
                        op_a_next      = merge1;
                        op_a_next.done = blit_end;
                    end
                    else
                    begin
                        op_a_next.done = blit_end;
                    end

                    if (next_col >= {1'b0, cfg.bitmap_width})
                    begin
                        column_count_next = 8'd0;
                        if ({1'b0, pi_inc} >= pages)
                        begin
                            active_next     = 1'b0;
                            page_index_next = 6'd0;
                        end
                        else
                        begin
                            page_index_next = pi_inc;
                        end
                    end
                    else
                    begin
                        column_count_next = next_col[7:0];
                    end
                end
            end
            pbb_pkg::FUNC_READ:
            begin
                if (32'(read_address) < pbb_pkg::STORE_DEPTH)
                begin
                    op_a_next.kind = pbb_pkg::OP_READ;
                    op_a_next.addr = AW'(read_address);
                end
            end
            default:
            begin
                op_a_next = nop_op;
            end
        endcase
    end

    assign issue_valid = slot_valid_reg;
    assign issue_op    = slot_phase_reg ? op_b_reg : op_a_reg;
    assign fire        = slot_valid_reg && issue_ready;
    assign leaving     = fire && issue_op.last;
    assign in_stall    = hold || (slot_valid_reg && !leaving);
    assign accept      = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg       <= 1'b0;
            column_count_reg <= 8'd0;
            page_index_reg   <= 6'd0;
            slot_valid_reg   <= 1'b0;
            slot_phase_reg   <= 1'b0;
            slot_two_reg     <= 1'b0;
        end
        else if (accept)
        begin
            active_reg       <= active_next;
            column_count_reg <= column_count_next;
            page_index_reg   <= page_index_next;
            slot_valid_reg   <= 1'b1;
            slot_phase_reg   <= 1'b0;
            slot_two_reg     <= two_next;
        end
        else if (leaving)
        begin
            slot_valid_reg <= 1'b0;
            slot_phase_reg <= 1'b0;
        end
        else if (fire)
        begin
            slot_phase_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_a_reg <= op_a_next;
            op_b_reg <= op_b_next;
        end
    end

`ifndef SYNTHESIS
    // The second memory operation is only ever pending for a two-page byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        slot_phase_reg |-> (slot_valid_reg && slot_two_reg))
        else $error("second operation pending without a two-page byte");

    // A byte that touches two pages holds the input until its second operation has issued.
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !issue_op.last) |=> (slot_valid_reg && slot_phase_reg))
        else $error("two-page byte lost its second operation");
`endif

endmodule

// ===== design/pbb_store.sv =====
module pbb_store (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              op_valid,
    input  pbb_pkg::mem_op_t  issue_op,
    output logic              busy,
    output logic              pending,
    output pbb_pkg::result_t  res
);

    localparam int AW = pbb_pkg::ADDR_W;

    logic [7:0] mem [pbb_pkg::STORE_DEPTH];

    logic             clr_busy_reg;
    logic [AW-1:0]    clr_addr_reg;
    logic             m_valid_reg;
    pbb_pkg::mem_op_t m_op_reg;
    logic [7:0]       rdata_reg;
    logic             fwd_valid_reg;
    logic [AW-1:0]    fwd_addr_reg;
    logic [7:0]       fwd_data_reg;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic [7:0]    cur;
    logic [7:0]    merged;

    // The write of the previous cycle is not yet visible to this read.
    assign cur = (fwd_valid_reg && fwd_addr_reg == m_op_reg.addr) ? fwd_data_reg : rdata_reg;

    always_comb
    begin
        unique case (m_op_reg.mode)
            pbb_pkg::MODE_SET:   merged = cur | m_op_reg.mask;
            pbb_pkg::MODE_CLEAR: merged = cur & ~m_op_reg.mask;
            default:             merged = cur ^ m_op_reg.mask;
        endcase
    end

    assign wr_en   = clr_busy_reg || (m_valid_reg && m_op_reg.kind == pbb_pkg::OP_MERGE);
    assign wr_addr = clr_busy_reg ? clr_addr_reg : m_op_reg.addr;
    assign wr_data = clr_busy_reg ? 8'd0 : merged;

    assign busy          = clr_busy_reg;
    assign pending       = m_valid_reg && m_op_reg.last;
    assign res.valid     = m_valid_reg && m_op_reg.last;
    assign res.read_data = (m_op_reg.kind == pbb_pkg::OP_READ) ? cur : 8'd0;
    assign res.blit_done = m_op_reg.done;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (op_valid)
        begin
            rdata_reg <= mem[issue_op.addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            m_valid_reg   <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            if (clr_busy_reg)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(pbb_pkg::STORE_DEPTH - 1))
                begin
                    clr_busy_reg <= 1'b0;
                end
            end
            m_valid_reg   <= op_valid;
            fwd_valid_reg <= wr_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op_valid)
        begin
            m_op_reg <= issue_op;
        end
        fwd_addr_reg <= wr_addr;
        fwd_data_reg <= wr_data;
    end

`ifndef SYNTHESIS
    // No operation may start while the clearing pass owns the write port.
    assert property (@(posedge clk) disable iff (!rst_n)
        op_valid |-> !clr_busy_reg)
        else $error("operation issued during clearing pass");

    assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> !m_valid_reg)
        else $error("modify stage active during clearing pass");
`endif

endmodule

// ===== design/page_bitmap_blit_unit.sv =====
// Page-mode bitmap blitter with a 1024-byte monochrome framebuffer (128 columns by 8 pages).
// Configuration: a write on cfg_valid/cfg_ready (cfg_ready is always high) sets the
// placement register named by cfg_index from cfg_data; indexes past the list are ignored.
// Input channel (in_valid/in_stall): func 0 arms a blit, func 1 delivers one bitmap column
// byte, func 2 reads the framebuffer byte at read_address. Every input transfer produces
// exactly one result transfer on out_valid/out_stall, in order: read_data carries the byte
// for a read and is zero otherwise, blit_done marks the end of a blit.
// A result is registered in the issue slot, the store's modify stage and the result queue.
// Throughput: one item per cycle unless the clearing pass or out_stall holds the input;
// a byte that spans two pages holds the input for its second merge, because each merge is a
// read-modify-write through the framebuffer's single write port.
// Back-to-back merges into the same byte are forwarded from the previous write.
// A two-entry result queue decouples the output; when out_stall holds, the queue fills
// and in_stall rises once no further result could be stored.
// Reset clears the placement registers and the blit state, then a clearing pass writes
// zero to all 1024 framebuffer bytes, one per cycle; in_stall stays high for the whole
// pass. Configuration writes are taken during the pass.
module page_bitmap_blit_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pbb_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]                      cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      func,
    input  logic [7:0]                      bitmap_byte,
    input  logic [9:0]                      read_address,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [7:0]                      read_data,
    output logic                            blit_done
);

    logic [7:0] origin_x_reg;
    logic [7:0] origin_y_reg;
    logic [7:0] bitmap_width_reg;
    logic [7:0] bitmap_height_reg;
    logic [1:0] draw_mode_reg;

    pbb_pkg::blit_cfg_t cfg;
    pbb_pkg::mem_op_t   issue_op;
    pbb_pkg::result_t   res;
    logic               issue_valid, issue_ready, store_busy, pending;

    logic [8:0] q_data [2];
    logic       q_wr_ptr_reg, q_rd_ptr_reg;
    logic [1:0] q_cnt_reg, q_cnt_next;
    logic       pop;
    logic [2:0] in_flight;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg      <= 8'd0;
            origin_y_reg      <= 8'd0;
            bitmap_width_reg  <= 8'd0;
            bitmap_height_reg <= 8'd0;
            draw_mode_reg     <= 2'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                pbb_pkg::CFG_ORIGIN_X:      origin_x_reg      <= cfg_data;
                pbb_pkg::CFG_ORIGIN_Y:      origin_y_reg      <= cfg_data;
                pbb_pkg::CFG_BITMAP_WIDTH:  bitmap_width_reg  <= cfg_data;
                pbb_pkg::CFG_BITMAP_HEIGHT: bitmap_height_reg <= cfg_data;
                pbb_pkg::CFG_DRAW_MODE:     draw_mode_reg     <= cfg_data[1:0];
                default:                    draw_mode_reg     <= draw_mode_reg;
            endcase
        end
    end

    assign cfg.origin_x      = origin_x_reg;
    assign cfg.origin_y      = origin_y_reg;
    assign cfg.bitmap_width  = bitmap_width_reg;
    assign cfg.bitmap_height = bitmap_height_reg;
    assign cfg.draw_mode     = draw_mode_reg;

    // An operation may start only if its result will find room in the queue.
    assign pop         = out_valid && !out_stall;
    assign in_flight   = 3'(q_cnt_reg) - 3'(pop) + 3'(pending);
    assign issue_ready = !store_busy && (in_flight < 3'd2);

    pbb_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .hold         (store_busy),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .bitmap_byte  (bitmap_byte),
        .read_address (read_address),
        .issue_valid  (issue_valid),
        .issue_ready  (issue_ready),
        .issue_op     (issue_op)
    );

    pbb_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (issue_valid && issue_ready),
        .issue_op (issue_op),
        .busy     (store_busy),
        .pending  (pending),
        .res      (res)
    );

    assign q_cnt_next = q_cnt_reg + 2'(res.valid) - 2'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_cnt_reg    <= 2'd0;
            q_wr_ptr_reg <= 1'b0;
            q_rd_ptr_reg <= 1'b0;
        end
        else
        begin
            q_cnt_reg <= q_cnt_next;
            if (res.valid)
            begin
                q_wr_ptr_reg <= !q_wr_ptr_reg;
            end
            if (pop)
            begin
                q_rd_ptr_reg <= !q_rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            q_data[q_wr_ptr_reg] <= {res.read_data, res.blit_done};
        end
    end

    assign out_valid = (q_cnt_reg != 2'd0);
    assign read_data = q_data[q_rd_ptr_reg][8:1];
    assign blit_done = q_data[q_rd_ptr_reg][0];

`ifndef SYNTHESIS
    // The issue credit must keep the result queue from overflowing.
    assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> !(q_cnt_reg == 2'd2 && !pop))
        else $error("result arrived with the queue full");

    assert property (@(posedge clk) disable iff (!rst_n)
        q_cnt_reg != 2'd3)
        else $error("result queue count out of range");
`endif

endmodule
